@@ hw/rtl/run_nearest_rssi_match_assert.svh @@
// ----------------------------------------------------------------------------
// run_nearest_rssi_match_assert.svh
// Assertion macros shared by the run_nearest_rssi_match RTL.
// ----------------------------------------------------------------------------
`ifndef RUN_NEAREST_RSSI_MATCH_ASSERT_SVH
`define RUN_NEAREST_RSSI_MATCH_ASSERT_SVH

`ifndef ASSERT_OFF

// Property must hold on every clock edge outside reset.
`define RNRM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define RNRM_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define RNRM_ASSERT(label, clk, rst_n, prop, msg)
`define RNRM_ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

@@ hw/rtl/rnrm_pkg.sv @@
// ----------------------------------------------------------------------------
// rnrm_pkg
// Types and constants for the nearest-strength run matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rnrm_pkg;

	localparam int RSSI_W = 12;
	localparam int DIFF_W = 13;
	localparam int DIST_W = 24;
	localparam int VAR_W  = 16;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Register indexes (paddr[2])
	localparam logic REG_TARGET_RSSI = 1'b0;
	localparam logic REG_MATCH_RANGE = 1'b1;

	localparam logic signed [RSSI_W-1:0] TARGET_RSSI_RST = -12'sd960;
	localparam logic [RSSI_W-1:0]        MATCH_RANGE_RST = 12'd32;

	typedef struct packed {
		logic signed [RSSI_W-1:0] rssi;
		logic [DIST_W-1:0]        distance;
		logic [VAR_W-1:0]         variance;
		logic                     last;
	} point_t;

	typedef struct packed {
		logic signed [RSSI_W-1:0] target_rssi;
		logic [RSSI_W-1:0]        match_range;
	} cfg_t;

	typedef struct packed {
		logic              emit;
		logic [DIST_W-1:0] distance;
		logic [VAR_W-1:0]  variance;
	} result_t;

endpackage

`default_nettype wire

@@ hw/rtl/rnrm_match.sv @@
// ----------------------------------------------------------------------------
// rnrm_match
// Run tracking: strength difference, window check, best-point state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "run_nearest_rssi_match_assert.svh"

module rnrm_match (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        step,
	input  wire rnrm_pkg::point_t      pt,
	input  wire rnrm_pkg::cfg_t        cfg,
	output rnrm_pkg::result_t          res
);

	logic                              in_run_q;
	logic [rnrm_pkg::DIFF_W-1:0]       best_diff_q;
	logic [rnrm_pkg::DIST_W-1:0]       best_dist_q;
	logic [rnrm_pkg::VAR_W-1:0]        best_var_q;

	logic signed [rnrm_pkg::DIFF_W-1:0] delta;
	logic [rnrm_pkg::DIFF_W-1:0]        diff;
	logic                               in_window;
	logic                               take;

	// 13-bit signed difference; magnitude is at most 4095
	assign delta    = {pt.rssi[rnrm_pkg::RSSI_W-1], pt.rssi}
	                - {cfg.target_rssi[rnrm_pkg::RSSI_W-1], cfg.target_rssi};
	assign diff     = delta[rnrm_pkg::DIFF_W-1] ? rnrm_pkg::DIFF_W'(-delta)
	                                            : rnrm_pkg::DIFF_W'(delta);
	assign in_window = diff < {1'b0, cfg.match_range};
	// earlier point wins a tie
	assign take     = in_window && (!in_run_q || diff < best_diff_q);

	assign res.emit     = step && !in_window && in_run_q;
	assign res.distance = best_dist_q;
	assign res.variance = best_var_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_run_q    <= 1'b0;
			best_diff_q <= '0;
			best_dist_q <= '0;
			best_var_q  <= '0;
		end else if (step) begin
			if (pt.last || (!in_window && in_run_q)) begin
				in_run_q    <= 1'b0;
				best_diff_q <= '0;
				best_dist_q <= '0;
				best_var_q  <= '0;
			end else if (in_window) begin
				in_run_q <= 1'b1;
				if (take) begin
					best_diff_q <= diff;
					best_dist_q <= pt.distance;
					best_var_q  <= pt.variance;
				end
			end
		end
	end

	`RNRM_ASSERT(a_emit_needs_run, clk, arst_n, res.emit |-> in_run_q, "emit without open run")
	`RNRM_ASSERT(a_last_closes_run, clk, arst_n, (step && pt.last) |=> !in_run_q, "run open after last")
	`RNRM_ASSERT(a_idle_state_clear, clk, arst_n, !in_run_q |-> (best_diff_q == '0), "stale best diff")

endmodule

`default_nettype wire

@@ hw/rtl/run_nearest_rssi_match.sv @@
// ----------------------------------------------------------------------------
// run_nearest_rssi_match
// Reports the closest-strength point of each run inside the target window.
// ----------------------------------------------------------------------------
//   Input channel (in_valid/in_stall) carries one map point per transaction:
//   point_rssi, point_distance, point_variance and is_last.
//   Output channel (out_valid/out_stall) carries one transaction per finished
//   run: match_distance and match_variance of the kept point.
//   A run ends on the first point outside the window; a run still open when
//   is_last arrives on a point inside the window is dropped; is_last always
//   clears the run state. An accepted point waits in the input register; the
//   result it closes is captured in the result register and drives out_valid.
//   Throughput: one point per cycle while unstalled, set by the single compare
//   stage between the input register and the run-state/result registers.
//   When the receiver stalls, the result register holds and one more point
//   waits in the input register; in_stall rises only when both are full.
//   Reset (arst_n low) empties both registers, closes any run and loads the
//   register defaults: target_rssi -960, match_range 32.
//   Registers (APB): 0x0 target_rssi, 0x4 match_range; write only while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "run_nearest_rssi_match_assert.svh"

module run_nearest_rssi_match (
	input  wire                                  clk,
	input  wire                                  arst_n,

	// APB register port
	input  wire                                  psel,
	input  wire                                  penable,
	input  wire                                  pwrite,
	input  wire  [rnrm_pkg::PADDR_W-1:0]         paddr,
	input  wire  [rnrm_pkg::PDATA_W-1:0]         pwdata,
	output logic [rnrm_pkg::PDATA_W-1:0]         prdata,
	output logic                                 pready,

	// point input
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire  signed [rnrm_pkg::RSSI_W-1:0]   point_rssi,
	input  wire  [rnrm_pkg::DIST_W-1:0]          point_distance,
	input  wire  [rnrm_pkg::VAR_W-1:0]           point_variance,
	input  wire                                  is_last,

	// match output
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic [rnrm_pkg::DIST_W-1:0]          match_distance,
	output logic [rnrm_pkg::VAR_W-1:0]           match_variance
);

	rnrm_pkg::cfg_t    cfg_q;
	rnrm_pkg::point_t  point_s1;
	logic              valid_s1;
	logic              out_valid_q;
	logic [rnrm_pkg::DIST_W-1:0] out_dist_q;
	logic [rnrm_pkg::VAR_W-1:0]  out_var_q;

	logic              advance;   // output register can take a new value
	logic              step;      // input-register point is evaluated
	logic              cfg_wr;
	rnrm_pkg::result_t res;

	// ---------------- register port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_rssi <= rnrm_pkg::TARGET_RSSI_RST;
			cfg_q.match_range <= rnrm_pkg::MATCH_RANGE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				rnrm_pkg::REG_TARGET_RSSI: begin
					cfg_q.target_rssi <= pwdata[rnrm_pkg::RSSI_W-1:0];
				end
				rnrm_pkg::REG_MATCH_RANGE: begin
					cfg_q.match_range <= pwdata[rnrm_pkg::RSSI_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			rnrm_pkg::REG_TARGET_RSSI: begin
				prdata = {{(rnrm_pkg::PDATA_W-rnrm_pkg::RSSI_W){1'b0}}, cfg_q.target_rssi};
			end
			rnrm_pkg::REG_MATCH_RANGE: begin
				prdata = {{(rnrm_pkg::PDATA_W-rnrm_pkg::RSSI_W){1'b0}}, cfg_q.match_range};
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	// ---------------- flow control ----------------
	// The input register drains whenever the result register is free or being
	// taken; it refills in the same cycle, so points stream one per clock.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign step     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			point_s1.rssi     <= point_rssi;
			point_s1.distance <= point_distance;
			point_s1.variance <= point_variance;
			point_s1.last     <= is_last;
		end
	end

	// ---------------- run tracking ----------------
	rnrm_match u_match (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.pt     (point_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (res.emit) begin
			out_dist_q <= res.distance;
			out_var_q  <= res.variance;
		end
	end

	assign out_valid      = out_valid_q;
	assign match_distance = out_dist_q;
	assign match_variance = out_var_q;

	// ---------------- checks ----------------
	`RNRM_ASSERT(a_stall_only_when_full, clk, arst_n, in_stall |-> (valid_s1 && out_valid_q), "stall with room")
	`RNRM_ASSERT(a_point_kept, clk, arst_n, (valid_s1 && !advance) |=> valid_s1, "stalled point lost")
	`RNRM_ASSERT(a_result_from_step, clk, arst_n, $rose(out_valid_q) |-> $past(step), "result without point")

endmodule

`default_nettype wire
